/* rtl/lcdw_pkg.sv */
// Shared types, codes and constants for the character LCD parallel write controller.
// No dependencies; imported by the config registers, core, top level and testbench.
`default_nettype none

package lcdw_pkg;

  localparam int NUM_ROWS_DEF = 4;

  localparam int WAIT_W = 20;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_DATA   = 3'd1,
    OP_CMD    = 3'd2,
    OP_CURSOR = 3'd3,
    OP_INIT   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CFG_SETUP_WAIT  = 3'd0,
    CFG_ENABLE_PULSE = 3'd1,
    CFG_SLOW_WAIT   = 3'd2,
    CFG_POWER_WAIT  = 3'd3,
    CFG_SECOND_WAIT = 3'd4,
    CFG_THIRD_WAIT  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SETUP = 3'd1,
    PH_PULSE = 3'd2,
    PH_SLOW  = 3'd3,
    PH_POWER = 3'd4,
    PH_GAP   = 3'd5
  } phase_t;

  localparam logic [7:0]  SETUP_WAIT_RST   = 8'd40;
  localparam logic [3:0]  ENABLE_PULSE_RST = 4'd3;
  localparam logic [15:0] SLOW_WAIT_RST    = 16'd2000;
  localparam logic [19:0] POWER_WAIT_RST   = 20'd40000;
  localparam logic [15:0] SECOND_WAIT_RST  = 16'd5000;
  localparam logic [15:0] THIRD_WAIT_RST   = 16'd1000;

  localparam logic [7:0] CURSOR_BASE = 8'h80;
  localparam logic [7:0] SLOW_CMD_LIMIT = 8'd4;
  localparam logic [2:0] INIT_LAST_STEP = 3'd7;

  typedef struct packed {
    logic [7:0]  setup_wait;
    logic [3:0]  enable_pulse;
    logic [15:0] slow_wait;
    logic [19:0] power_wait;
    logic [15:0] second_wait;
    logic [15:0] third_wait;
  } cfg_regs_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] byte_value;
    logic [4:0] column;
    logic [2:0] row;
  } item_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic       enable_pin;
    logic [7:0] data_bus;
    logic       busy_res;
    logic       dropped;
  } result_t;

  // Power-on command sequence, indexed by init step (step 0 unused).
  function automatic logic [7:0] init_cmd(input logic [2:0] step);
    logic [7:0] c;
    case (step)
      3'd1:    c = 8'h38;
      3'd2:    c = 8'h38;
      3'd3:    c = 8'h08;
      3'd4:    c = 8'h01;
      3'd5:    c = 8'h06;
      3'd6:    c = 8'h02;
      3'd7:    c = 8'h0C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // DDRAM start address of each row of a 4-line display.
  function automatic logic [7:0] row_offset(input logic [1:0] r);
    logic [7:0] o;
    case (r)
      2'd0:    o = 8'd0;
      2'd1:    o = 8'd64;
      2'd2:    o = 8'd20;
      default: o = 8'd84;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

/* rtl/lcdw_ifs.sv */
// Handshake channels of the LCD write controller: request, result and register write.
// Plain valid/ready interfaces; no package dependency.
`default_nettype none

interface lcdw_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] byte_value;
  logic [4:0] column;
  logic [2:0] row;
  modport source (output valid, output op, output byte_value, output column, output row,
                  input ready);
  modport sink (input valid, input op, input byte_value, input column, input row,
                output ready);
endinterface

interface lcdw_res_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic       read_write;
  logic       enable_pin;
  logic [7:0] data_bus;
  logic       busy_res;
  logic       dropped;
  modport source (output valid, output reg_select, output read_write, output enable_pin,
                  output data_bus, output busy_res, output dropped, input ready);
  modport sink (input valid, input reg_select, input read_write, input enable_pin,
                input data_bus, input busy_res, input dropped, output ready);
endinterface

interface lcdw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/lcdw_cfg_regs.sv */
// Timing register file of the LCD write controller, written over the config channel.
// Depends on lcdw_pkg and lcdw_cfg_if.
`default_nettype none

module lcdw_cfg_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  lcdw_cfg_if.sink                cfg,
  output lcdw_pkg::cfg_regs_t     regs
);
  import lcdw_pkg::*;

  cfg_regs_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.setup_wait   <= SETUP_WAIT_RST;
      regs_q.enable_pulse <= ENABLE_PULSE_RST;
      regs_q.slow_wait    <= SLOW_WAIT_RST;
      regs_q.power_wait   <= POWER_WAIT_RST;
      regs_q.second_wait  <= SECOND_WAIT_RST;
      regs_q.third_wait   <= THIRD_WAIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_SETUP_WAIT:   regs_q.setup_wait   <= cfg.data[7:0];
        CFG_ENABLE_PULSE: regs_q.enable_pulse <= cfg.data[3:0];
        CFG_SLOW_WAIT:    regs_q.slow_wait    <= cfg.data[15:0];
        CFG_POWER_WAIT:   regs_q.power_wait   <= cfg.data;
        CFG_SECOND_WAIT:  regs_q.second_wait  <= cfg.data[15:0];
        CFG_THIRD_WAIT:   regs_q.third_wait   <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/lcdw_core.sv */
// Bus timing state machine: phase, wait counter, init sequencer and pin levels.
// Processes one registered item per go cycle; depends on lcdw_pkg.
`default_nettype none

module lcdw_core #(
  parameter int NumRows = lcdw_pkg::NUM_ROWS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                go,
  input  wire lcdw_pkg::item_t     item,
  input  wire lcdw_pkg::cfg_regs_t regs,
  output lcdw_pkg::result_t        result
);
  import lcdw_pkg::*;

  typedef struct packed {
    phase_t            phase;
    logic [2:0]        step;
    logic [WAIT_W-1:0] wait_cnt;
    logic              load_byte;
    logic [7:0]        byte_value;
  } finish_t;

  localparam logic [2:0] ROWS_MAX = 3'(NumRows);

  phase_t            phase, phase_next;
  logic [WAIT_W-1:0] wait_cnt, wait_cnt_next;
  logic [2:0]        step, step_next;
  logic [7:0]        pend_byte, pend_byte_next;
  logic              pend_data, pend_data_next;
  logic              pin_rs, pin_rs_next;
  logic              pin_en, pin_en_next;
  logic [7:0]        pin_data, pin_data_next;

  op_t               op;
  logic              busy, is_tick, is_req, expire, slow_cmd;
  logic [WAIT_W-1:0] wait_dec;
  logic [2:0]        row_clamp;
  logic [7:0]        cursor_byte;
  finish_t           fin;

  assign op       = op_t'(item.op);
  assign busy     = (phase != PH_IDLE);
  assign is_tick  = (item.op == OP_TICK);
  assign is_req   = (item.op == OP_DATA) || (item.op == OP_CMD) ||
                    (item.op == OP_CURSOR) || (item.op == OP_INIT);
  assign wait_dec = (wait_cnt != '0) ? wait_cnt - 1'b1 : wait_cnt;
  assign expire   = is_tick && busy && (wait_dec == '0);
  assign slow_cmd = !pend_data && (pend_byte < SLOW_CMD_LIMIT);

  assign row_clamp = (item.row == 3'd0) ? 3'd1 :
                     (item.row > ROWS_MAX) ? ROWS_MAX : item.row;
  assign cursor_byte = CURSOR_BASE + row_offset(2'(row_clamp - 3'd1)) +
                       {3'b000, item.column} - 8'd1;

  // What follows the end of a write, by init step.
  always_comb begin
    fin.phase      = PH_IDLE;
    fin.step       = step;
    fin.wait_cnt   = '0;
    fin.load_byte  = 1'b0;
    fin.byte_value = init_cmd(step + 3'd1);
    case (step)
      3'd0: ;
      3'd1: begin
        fin.phase    = PH_GAP;
        fin.step     = 3'd2;
        fin.wait_cnt = WAIT_W'(regs.second_wait);
      end
      3'd2: begin
        fin.phase    = PH_GAP;
        fin.step     = 3'd3;
        fin.wait_cnt = WAIT_W'(regs.third_wait);
      end
      INIT_LAST_STEP: fin.step = 3'd0;
      default: begin
        fin.phase     = PH_SETUP;
        fin.step      = step + 3'd1;
        fin.wait_cnt  = WAIT_W'(regs.setup_wait);
        fin.load_byte = 1'b1;
      end
    endcase
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (expire) begin
      unique case (phase)
        PH_SETUP:         phase_next = PH_PULSE;
        PH_PULSE:         phase_next = slow_cmd ? PH_SLOW : fin.phase;
        PH_SLOW:          phase_next = fin.phase;
        PH_POWER, PH_GAP: phase_next = PH_SETUP;
        default:          phase_next = PH_IDLE;
      endcase
    end else if (is_req && !busy) begin
      phase_next = (op == OP_INIT) ? PH_POWER : PH_SETUP;
    end
  end

  // Counter, sequencer, pending byte and pins
  always_comb begin
    wait_cnt_next  = wait_cnt;
    step_next      = step;
    pend_byte_next = pend_byte;
    pend_data_next = pend_data;
    pin_rs_next    = pin_rs;
    pin_en_next    = pin_en;
    pin_data_next  = pin_data;
    if (is_tick && busy) begin
      wait_cnt_next = wait_dec;
      if (expire) begin
        unique case (phase)
          PH_SETUP: begin
            pin_rs_next   = pend_data;
            pin_en_next   = 1'b1;
            pin_data_next = pend_byte;
            wait_cnt_next = WAIT_W'(regs.enable_pulse);
          end
          PH_PULSE, PH_SLOW: begin
            pin_en_next = (phase == PH_PULSE) ? 1'b0 : pin_en;
            if (phase == PH_PULSE && slow_cmd) begin
              wait_cnt_next = WAIT_W'(regs.slow_wait);
            end else begin
              step_next     = fin.step;
              wait_cnt_next = fin.wait_cnt;
              if (fin.load_byte) begin
                pend_byte_next = fin.byte_value;
                pend_data_next = 1'b0;
              end
            end
          end
          PH_POWER, PH_GAP: begin
            pend_byte_next = init_cmd(step);
            pend_data_next = 1'b0;
            wait_cnt_next  = WAIT_W'(regs.setup_wait);
          end
          default: step_next = 3'd0;
        endcase
      end
    end else if (is_req && !busy) begin
      unique case (op)
        OP_DATA, OP_CMD: begin
          pend_byte_next = item.byte_value;
          pend_data_next = (op == OP_DATA);
          wait_cnt_next  = WAIT_W'(regs.setup_wait);
        end
        OP_CURSOR: begin
          pend_byte_next = cursor_byte;
          pend_data_next = 1'b0;
          wait_cnt_next  = WAIT_W'(regs.setup_wait);
        end
        default: begin
          pin_rs_next   = 1'b0;
          pin_en_next   = 1'b0;
          pin_data_next = '0;
          step_next     = 3'd1;
          wait_cnt_next = regs.power_wait;
        end
      endcase
    end
  end

  always_comb begin
    result.reg_select = pin_rs_next;
    result.read_write = 1'b0;
    result.enable_pin = pin_en_next;
    result.data_bus   = pin_data_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.dropped    = is_req && busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      wait_cnt  <= '0;
      step      <= 3'd0;
      pend_byte <= '0;
      pend_data <= 1'b0;
      pin_rs    <= 1'b0;
      pin_en    <= 1'b0;
      pin_data  <= '0;
    end else if (go) begin
      phase     <= phase_next;
      wait_cnt  <= wait_cnt_next;
      step      <= step_next;
      pend_byte <= pend_byte_next;
      pend_data <= pend_data_next;
      pin_rs    <= pin_rs_next;
      pin_en    <= pin_en_next;
      pin_data  <= pin_data_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/char_lcd_parallel_write_controller.sv */
// LCD write controller top: input register, timing core, result register.
// An accepted request beat is held in the input register; its result is registered in the result register.
// One item per cycle when not stalled; the core state updates once per item.
// Stalls only when the result register is full and not being taken.
// Synchronous active-high reset: pins low, idle, timing registers at defaults.
// Depends on lcdw_pkg, lcdw_ifs, lcdw_cfg_regs and lcdw_core.
`default_nettype none

module char_lcd_parallel_write_controller #(
  parameter int NUM_ROWS = lcdw_pkg::NUM_ROWS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lcdw_req_if.sink   req,
  lcdw_res_if.source res,
  lcdw_cfg_if.sink   cfg
);
  import lcdw_pkg::*;

  cfg_regs_t regs;
  item_t     item;
  result_t   core_res, res_q;
  logic      item_valid, res_valid, go;

  assign go        = item_valid && (!res_valid || res.ready);
  assign req.ready = !item_valid || go;

  lcdw_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lcdw_core #(.NumRows(NUM_ROWS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (item),
    .regs   (regs),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.op         <= req.op;
      item.byte_value <= req.byte_value;
      item.column     <= req.column;
      item.row        <= req.row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_q <= core_res;
    end
  end

  assign res.valid      = res_valid;
  assign res.reg_select = res_q.reg_select;
  assign res.read_write = res_q.read_write;
  assign res.enable_pin = res_q.enable_pin;
  assign res.data_bus   = res_q.data_bus;
  assign res.busy_res   = res_q.busy_res;
  assign res.dropped    = res_q.dropped;

endmodule

`default_nettype wire

/* rtl/lcdw_checker.sv */
// Port-level checks for the LCD write controller, bound to the top level.
// No package dependency; sees only the top-level channel signals.
`default_nettype none

module lcdw_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       res_read_write,
  input wire logic       res_enable_pin,
  input wire logic [7:0] res_data_bus,
  input wire logic       res_busy_res,
  input wire logic       res_dropped
);

  // Nothing comes out in the cycle after reset.
  a_no_res_after_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data_bus))
    else $error("stalled result beat changed");

  // A dropped request means the controller was busy and still is.
  a_drop_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_dropped |-> res_busy_res)
    else $error("dropped flag without busy");

  // Enable is only high inside a write pulse.
  a_en_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_enable_pin |-> res_busy_res)
    else $error("enable high while idle");

  a_rw_low: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !res_read_write)
    else $error("read/write pin not low");

endmodule

bind char_lcd_parallel_write_controller lcdw_checker u_lcdw_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_read_write (res.read_write),
  .res_enable_pin (res.enable_pin),
  .res_data_bus   (res.data_bus),
  .res_busy_res   (res.busy_res),
  .res_dropped    (res.dropped)
);

`default_nettype wire

/* dv/tb_top.sv */
// Testbench for the character LCD parallel write controller: random and directed
// request/tick streams checked beat by beat against an in-bench pin-level predictor.
// Depends on lcdw_pkg, lcdw_ifs and the char_lcd_parallel_write_controller RTL.
`default_nettype none

module tb_top;
  import lcdw_pkg::*;

  localparam int NUM_ROWS = NUM_ROWS_DEF;
  localparam int OP_CODES = 8;
  localparam int PIN_EN = 8;
  localparam int PIN_RS = 10;
  // Quiet limit: longest receiver hold-off plus config writes and drain, with margin.
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_LEN = 150;

  // Power-on byte sequence by step (step 0 unused) and DDRAM row bases.
  localparam logic [7:0][7:0] INIT_SEQ = {8'h0C, 8'h02, 8'h06, 8'h01,
                                          8'h08, 8'h38, 8'h38, 8'h00};
  localparam logic [3:0][7:0] ROW_BASE = {8'd84, 8'd20, 8'd64, 8'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  lcdw_req_if req_ch ();
  lcdw_res_if res_ch ();
  lcdw_cfg_if cfg_ch ();

  logic        req_valid = 1'b0;
  item_t       req_item = '0;
  logic        res_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  assign req_ch.valid      = req_valid;
  assign req_ch.op         = req_item.op;
  assign req_ch.byte_value = req_item.byte_value;
  assign req_ch.column     = req_item.column;
  assign req_ch.row        = req_item.row;
  assign res_ch.ready      = res_ready;
  assign cfg_ch.valid      = cfg_valid;
  assign cfg_ch.index      = cfg_index;
  assign cfg_ch.data       = cfg_data;

  char_lcd_parallel_write_controller #(.NUM_ROWS(NUM_ROWS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  item_t   requests_todo[$];
  result_t pin_states_due[$];
  int      items_queued = 0;
  int      items_taken = 0;
  int      results_seen = 0;
  int      errors = 0;
  logic    req_beat = 1'b0;
  logic    cfg_beat = 1'b0;
  int      quiet_cycles = 0;
  int      gen_cfg [6];

  // ---------------------------------------------------------------------------
  // Pin-level predictor of the controller

  phase_t      ph;
  logic [19:0] wait_cnt;
  logic [3:0]  init_idx;
  logic [7:0]  pend_byte;
  logic        pend_data;
  logic [10:0] pins;
  logic [7:0]  cur_setup;
  logic [3:0]  cur_pulse;
  logic [15:0] cur_slow;
  logic [19:0] cur_power;
  logic [15:0] cur_second;
  logic [15:0] cur_third;

  function automatic void lcd_model_reset();
    ph         = PH_IDLE;
    wait_cnt   = '0;
    init_idx   = '0;
    pend_byte  = '0;
    pend_data  = 1'b0;
    pins       = '0;
    cur_setup  = SETUP_WAIT_RST;
    cur_pulse  = ENABLE_PULSE_RST;
    cur_slow   = SLOW_WAIT_RST;
    cur_power  = POWER_WAIT_RST;
    cur_second = SECOND_WAIT_RST;
    cur_third  = THIRD_WAIT_RST;
  endfunction

  function automatic void load_write(input logic [7:0] b, input logic is_data);
    pend_byte = b;
    pend_data = is_data;
    ph        = PH_SETUP;
    wait_cnt  = 20'(cur_setup);
  endfunction

  function automatic void end_write();
    if (init_idx == 4'd0) begin
      ph = PH_IDLE;
    end else if (init_idx == 4'd1) begin
      init_idx = 4'd2;
      ph       = PH_GAP;
      wait_cnt = 20'(cur_second);
    end else if (init_idx == 4'd2) begin
      init_idx = 4'd3;
      ph       = PH_GAP;
      wait_cnt = 20'(cur_third);
    end else if (init_idx >= 4'(INIT_LAST_STEP)) begin
      init_idx = 4'd0;
      ph       = PH_IDLE;
    end else begin
      init_idx = init_idx + 4'd1;
      load_write(INIT_SEQ[init_idx[2:0]], 1'b0);
    end
  endfunction

  // One microsecond; the wait that expires acts on this same tick.
  function automatic void us_tick();
    if (ph == PH_IDLE) return;
    if (wait_cnt != '0) wait_cnt = wait_cnt - 20'd1;
    if (wait_cnt != '0) return;
    case (ph)
      PH_SETUP: begin
        pins     = {pend_data, 1'b0, 1'b1, pend_byte};
        ph       = PH_PULSE;
        wait_cnt = 20'(cur_pulse);
      end
      PH_PULSE: begin
        pins[PIN_EN] = 1'b0;
        if (!pend_data && pend_byte < SLOW_CMD_LIMIT) begin
          ph       = PH_SLOW;
          wait_cnt = 20'(cur_slow);
        end else begin
          end_write();
        end
      end
      PH_SLOW: end_write();
      PH_POWER, PH_GAP: load_write(INIT_SEQ[init_idx[2:0]], 1'b0);
      default: begin
        ph       = PH_IDLE;
        init_idx = '0;
      end
    endcase
  endfunction

  function automatic result_t lcd_bus_step(input item_t it);
    result_t    r;
    logic       dropped;
    logic [2:0] line;
    logic [7:0] addr;
    dropped = 1'b0;
    case (it.op)
      OP_TICK: us_tick();
      OP_DATA, OP_CMD, OP_CURSOR, OP_INIT: begin
        if (ph != PH_IDLE) begin
          dropped = 1'b1;
        end else if (it.op == OP_DATA) begin
          load_write(it.byte_value, 1'b1);
        end else if (it.op == OP_CMD) begin
          load_write(it.byte_value, 1'b0);
        end else if (it.op == OP_CURSOR) begin
          line = it.row;
          if (line < 3'd1) line = 3'd1;
          if (line > 3'(NUM_ROWS)) line = 3'(NUM_ROWS);
          addr = CURSOR_BASE + ROW_BASE[2'(line - 3'd1)] + {3'b000, it.column} - 8'd1;
          load_write(addr, 1'b0);
        end else begin
          pins     = '0;
          init_idx = 4'd1;
          ph       = PH_POWER;
          wait_cnt = cur_power;
        end
      end
      default: ;
    endcase
    r.reg_select = pins[PIN_RS];
    r.read_write = 1'b0;
    r.enable_pin = pins[PIN_EN];
    r.data_bus   = pins[7:0];
    r.busy_res   = (ph != PH_IDLE);
    r.dropped    = dropped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: config beats, request beats into the predictor, result checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    req_beat <= req_ch.valid && req_ch.ready;
    cfg_beat <= cfg_ch.valid && cfg_ch.ready;
    if (rst) begin
      lcd_model_reset();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_SETUP_WAIT:   cur_setup  = cfg_ch.data[7:0];
          CFG_ENABLE_PULSE: cur_pulse  = cfg_ch.data[3:0];
          CFG_SLOW_WAIT:    cur_slow   = cfg_ch.data[15:0];
          CFG_POWER_WAIT:   cur_power  = cfg_ch.data;
          CFG_SECOND_WAIT:  cur_second = cfg_ch.data[15:0];
          CFG_THIRD_WAIT:   cur_third  = cfg_ch.data[15:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        pin_states_due.push_back(lcd_bus_step('{op: req_ch.op, byte_value: req_ch.byte_value,
                                                column: req_ch.column, row: req_ch.row}));
        items_taken++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pin_states_due.size() == 0) begin
          report_mismatch("result with nothing expected", 0, 0);
        end else begin
          want = pin_states_due.pop_front();
          if (res_ch.reg_select !== want.reg_select)
            report_mismatch("reg_select", res_ch.reg_select, want.reg_select);
          if (res_ch.read_write !== want.read_write)
            report_mismatch("read_write", res_ch.read_write, want.read_write);
          if (res_ch.enable_pin !== want.enable_pin)
            report_mismatch("enable_pin", res_ch.enable_pin, want.enable_pin);
          if (res_ch.data_bus !== want.data_bus)
            report_mismatch("data_bus", res_ch.data_bus, want.data_bus);
          if (res_ch.busy_res !== want.busy_res)
            report_mismatch("busy_res", res_ch.busy_res, want.busy_res);
          if (res_ch.dropped !== want.dropped)
            report_mismatch("dropped", res_ch.dropped, want.dropped);
        end
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: bursts with random gaps

  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst && (req_beat || !req_valid)) begin
      if (gap_left > 0 || requests_todo.size() == 0) begin
        req_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        req_item  <= requests_todo.pop_front();
        req_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result receiver: rotating stall pattern, plus one long hold-off
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  logic [7:0] stall_pat = 8'hFF;
  int       pat_age = 0;

  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      res_ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age   = 64;
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      pat_age--;
      res_ready <= stall_pat[pat_age % 8];
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus

  function automatic int at_least_one(input int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int write_len(input logic [7:0] b, input logic is_data);
    int n;
    n = at_least_one(gen_cfg[CFG_SETUP_WAIT]) + at_least_one(gen_cfg[CFG_ENABLE_PULSE]);
    if (!is_data && b < SLOW_CMD_LIMIT) n += at_least_one(gen_cfg[CFG_SLOW_WAIT]);
    return n;
  endfunction

  // Ticks a request keeps the controller busy, under the current settings.
  function automatic int busy_len(input logic [2:0] op, input logic [7:0] b);
    case (op)
      OP_DATA:   return write_len(b, 1'b1);
      OP_CMD:    return write_len(b, 1'b0);
      OP_CURSOR: return write_len(CURSOR_BASE, 1'b0);
      OP_INIT:   return at_least_one(gen_cfg[CFG_POWER_WAIT]) +
                        at_least_one(gen_cfg[CFG_SECOND_WAIT]) +
                        at_least_one(gen_cfg[CFG_THIRD_WAIT]) +
                        2 * write_len(8'h38, 1'b0) + write_len(8'h08, 1'b0) +
                        write_len(8'h01, 1'b0) + write_len(8'h06, 1'b0) +
                        write_len(8'h02, 1'b0) + write_len(8'h0C, 1'b0);
      default:   return 0;
    endcase
  endfunction

  task automatic push_item(input logic [2:0] op, input logic [7:0] b,
                           input logic [4:0] col, input logic [2:0] row);
    requests_todo.push_back('{op: op, byte_value: b, column: col, row: row});
    items_queued++;
  endtask

  task automatic push_tick();
    push_item(OP_TICK, 8'($urandom), 5'($urandom), 3'($urandom));
  endtask

  // Request, then requests that land while busy (cycling through every
  // request op), then ticks up to one idle tick past completion.
  task automatic issue_request(input logic [2:0] op, input logic [7:0] b,
                               input logic [4:0] col, input logic [2:0] row, input int drops);
    push_item(op, b, col, row);
    for (int k = 0; k < drops; k++)
      push_item(3'(OP_DATA + k % 4), 8'($urandom), 5'($urandom), 3'($urandom));
    repeat (busy_len(op, b) + 1) push_tick();
  endtask

  task automatic random_traffic(input int target);
    int         first;
    int         len;
    logic [2:0] op;
    logic [7:0] b;
    first = items_queued;
    while (items_queued - first < target) begin
      if ($urandom_range(0, 99) < 8) begin
        push_item(3'($urandom_range(0, OP_CODES - 1)), 8'($urandom), 5'($urandom),
                  3'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0) op = OP_INIT;
        else op = 3'($urandom_range(OP_DATA, OP_CURSOR));
        b = 8'($urandom);
        push_item(op, b, 5'($urandom), 3'($urandom));
        len = busy_len(op, b);
        // cut short now and then so the next request finds the bus busy
        if ($urandom_range(0, 4) == 0) len = $urandom_range(0, len - 1);
        else len += $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 15) == 0)
            push_item(3'($urandom_range(OP_DATA, OP_CODES - 1)), 8'($urandom),
                      5'($urandom), 3'($urandom));
          push_tick();
        end
      end
    end
    // let any truncated sequence finish before the settings change
    repeat (busy_len(OP_INIT, 8'h00) + 1) push_tick();
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [19:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_beat);
    cfg_valid <= 1'b0;
    gen_cfg[idx] = int'(value);
  endtask

  task automatic set_timing(input int setup, input int pulse, input int slow,
                            input int power, input int second, input int third);
    write_reg(CFG_SETUP_WAIT, 20'(setup));
    write_reg(CFG_ENABLE_PULSE, 20'(pulse));
    write_reg(CFG_SLOW_WAIT, 20'(slow));
    write_reg(CFG_POWER_WAIT, 20'(power));
    write_reg(CFG_SECOND_WAIT, 20'(second));
    write_reg(CFG_THIRD_WAIT, 20'(third));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (!(items_taken == items_queued && pin_states_due.size() == 0));
    repeat (4) @(negedge clk);
  endtask

  initial begin
    gen_cfg[CFG_SETUP_WAIT]   = SETUP_WAIT_RST;
    gen_cfg[CFG_ENABLE_PULSE] = ENABLE_PULSE_RST;
    gen_cfg[CFG_SLOW_WAIT]    = SLOW_WAIT_RST;
    gen_cfg[CFG_POWER_WAIT]   = POWER_WAIT_RST;
    gen_cfg[CFG_SECOND_WAIT]  = SECOND_WAIT_RST;
    gen_cfg[CFG_THIRD_WAIT]   = THIRD_WAIT_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset timing: idle tick, unknown ops, a data write with every request op dropped
    push_tick();
    for (int u = OP_INIT + 1; u < OP_CODES; u++)
      push_item(3'(u), 8'hFF, 5'h1F, 3'h7);
    issue_request(OP_DATA, 8'hA5, 5'd0, 3'd0, 4);
    wait_drained();

    // All waits at their minimum: zero still lasts one tick
    set_timing(0, 1, 0, 0, 0, 0);
    issue_request(OP_CURSOR, 8'h00, 5'd1, 3'd0, 0);   // row zero taken as row one
    issue_request(OP_CURSOR, 8'hFF, 5'd1, 3'd1, 0);
    issue_request(OP_CURSOR, 8'h00, 5'd20, 3'd2, 0);
    issue_request(OP_CURSOR, 8'h00, 5'd5, 3'd3, 0);
    issue_request(OP_CURSOR, 8'h00, 5'd20, 3'd4, 0);
    issue_request(OP_CURSOR, 8'h00, 5'd3, 3'd5, 0);   // rows past the last clamp
    issue_request(OP_CURSOR, 8'h00, 5'd31, 3'd7, 0);
    issue_request(OP_CURSOR, 8'h00, 5'd0, 3'd2, 0);   // column zero wraps
    issue_request(OP_CMD, 8'h00, 5'd0, 3'd0, 0);      // slow commands
    issue_request(OP_CMD, 8'h03, 5'd0, 3'd0, 0);
    issue_request(OP_CMD, 8'h04, 5'd0, 3'd0, 0);
    issue_request(OP_CMD, 8'hFF, 5'd0, 3'd0, 0);
    issue_request(OP_DATA, 8'h00, 5'd0, 3'd0, 0);
    issue_request(OP_DATA, 8'hFF, 5'd31, 3'd7, 2);
    push_item(OP_INIT, 8'h00, 5'd0, 3'd0);
    for (int u = OP_INIT + 1; u < OP_CODES; u++)
      push_item(3'(u), 8'h00, 5'd0, 3'd0);             // unknown ops while busy
    repeat (busy_len(OP_INIT, 8'h00) + 1) push_tick();
    wait_drained();

    set_timing($urandom_range(0, 5), $urandom_range(1, 3), $urandom_range(0, 6),
               $urandom_range(0, 12), $urandom_range(0, 8), $urandom_range(0, 8));
    random_traffic(110);
    wait_drained();

    set_timing($urandom_range(1, 3), $urandom_range(1, 6), $urandom_range(0, 4),
               $urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 4));
    random_traffic(110);
    wait_drained();

    // Largest settings; only writes whose waits stay short run to completion
    set_timing(255, 15, 65535, 1048575, 65535, 65535);
    issue_request(OP_DATA, 8'h5A, 5'd0, 3'd0, 4);
    wait_drained();

    repeat (4) @(posedge clk);
    if (errors == 0 && pin_states_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
